// File: design/ttceb_pkg.sv
// ----------------------------------------------------------------------------
// ttceb_pkg
// Shared types, register map, constants and the cosine table generator for
// the time-to-collision emergency brake block.
// ----------------------------------------------------------------------------
package ttceb_pkg;

    // Field widths
    localparam int ANGLE_W      = 19;
    localparam int ANGLE_STEP_W = 16;
    localparam int TTC_W        = 16;
    localparam int MIN_BEAM_W   = 11;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 19;

    localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_THR   = 2'd2;

    localparam logic signed [ANGLE_W-1:0] START_ANGLE_RST = -19'sd154415;
    localparam logic [ANGLE_STEP_W-1:0]   ANGLE_STEP_RST  = 16'd286;
    localparam logic [TTC_W-1:0]          BRAKE_THR_RST   = 16'd1300;

    // Opcodes
    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_BEAM  = 1'b1;

    // 2*pi and pi in units of 2^-16 rad
    localparam logic [ANGLE_W-1:0] TWO_PI_UNITS = 19'd411775;
    localparam logic [ANGLE_W-1:0] HALF_TWO_PI  = 19'd205887;

    localparam logic [TTC_W-1:0] TTC_INF  = 16'hFFFF;
    localparam logic [9:0]       MS_PER_S = 10'd1000;

    localparam int QUEUE_DEPTH = 2;

    // Cosine table generation (elaboration only)
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam longint          TAYLOR_DEN [7] = '{182, 132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic                     is_beam;
        logic signed [15:0]       value;       // speed for updates, cos Q15 for beams
        logic [15:0]              range_mm;
        logic                     range_valid;
        logic                     last_beam;
    } q_entry_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_REDUCE,
        F_SCALE,
        F_INDEX,
        F_LOOKUP,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_CHECK,
        B_DIV,
        B_UPDATE
    } back_state_t;

    // cos over a quarter turn, u in Q30 within [0, 2^30], result Q15
    function automatic logic signed [15:0] quarter_cos(longint unsigned u);
        longint unsigned xu;
        longint          x;
        longint          x2;
        longint          t;
        xu = (u * HALF_PI_Q30) >> 30;
        x  = longint'(xu);
        x2 = (x * x) >>> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 7; i++) begin
            t = ONE_Q30 - ((x2 * t) >>> 30) / TAYLOR_DEN[i];
            if (t < 0) begin
                t = 0;
            end
        end
        t = (t + 64'sd16384) >>> 15;
        if (t > 32767) begin
            t = 32767;
        end
        return 16'(t);
    endfunction

    // table entry from its phase, phase in units of 2^-32 turn
    function automatic logic signed [15:0] cos_entry(longint unsigned phase);
        longint unsigned r;
        logic [1:0]      q;
        logic signed [15:0] v;
        q = phase[31:30];
        r = phase & 64'h3FFF_FFFF;
        case (q)
            2'd0:    v = quarter_cos(r);
            2'd1:    v = -quarter_cos(64'h4000_0000 - r);
            2'd2:    v = -quarter_cos(r);
            default: v = quarter_cos(64'h4000_0000 - r);
        endcase
        return v;
    endfunction

endpackage

// File: design/ttceb_fifo.sv
// ----------------------------------------------------------------------------
// ttceb_fifo
// Small register queue between the classify front and the compute back.
// ----------------------------------------------------------------------------
module ttceb_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/ttceb_front.sv
// ----------------------------------------------------------------------------
// ttceb_front
// Accepts requests, numbers the beams, reduces the beam angle modulo 2*pi,
// maps it to a cosine table index and looks up the Q15 cosine.
// ----------------------------------------------------------------------------
module ttceb_front
    import ttceb_pkg::*;
#(
    parameter int MAX_BEAMS       = 2048,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [ANGLE_W-1:0]     cfg_start_angle,
    input  logic [ANGLE_STEP_W-1:0]       cfg_angle_step,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [15:0]            s_speed_mm_s,
    input  logic [15:0]                   s_range_mm,
    input  logic                          s_range_valid,
    input  logic                          s_last_beam,
    output logic                          q_valid,
    input  logic                          q_ready,
    output q_entry_t                      q_entry,
    output logic [$clog2(MAX_BEAMS)-1:0]  q_beam
);

    localparam int BEAM_W    = $clog2(MAX_BEAMS);
    localparam int PROD_W    = BEAM_W + ANGLE_STEP_W;
    localparam int ACC_W     = ((PROD_W > ANGLE_W + 1) ? PROD_W : ANGLE_W + 1) + 1;
    localparam int IDX_W     = $clog2(COS_TABLE_DEPTH + 1);
    localparam int TIDX_W    = $clog2(COS_TABLE_DEPTH);
    localparam int NUM_W     = ANGLE_W + IDX_W;
    localparam int WORK_W    = (ACC_W > NUM_W) ? ACC_W : NUM_W;
    // 2*pi exceeds 2^18, so any quotient of a WORK_W-bit value fits QUOT_W bits
    localparam int QUOT_W    = WORK_W - ANGLE_W + 1;
    localparam int MULT_W    = WORK_W + QUOT_W;
    localparam logic [QUOT_W-1:0] RECIP =
        QUOT_W'((64'd1 << WORK_W) / 64'(TWO_PI_UNITS));
    localparam int STEP_W    = 2;
    localparam logic [STEP_W-1:0] STEP_MUL = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SUB = 2'd1;

    front_state_t       state_reg;
    front_state_t       state_next;
    logic [BEAM_W-1:0]  beam_cnt_reg;
    logic [BEAM_W-1:0]  beam_idx_reg;
    logic [WORK_W-1:0]  rem_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [IDX_W-1:0]   idx_reg;
    q_entry_t           entry_reg;

    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   acc_init;
    logic [MULT_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]  quot_est;
    logic [WORK_W-1:0]  quot_tp;
    logic               ge;
    logic [TIDX_W-1:0]  tidx;
    logic               accept;
    logic               is_beam_in;

    logic signed [15:0] cos_rom [COS_TABLE_DEPTH];

    for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
        localparam longint unsigned PHASE =
            (longint'(k) << 32) / longint'(COS_TABLE_DEPTH);
        localparam logic signed [15:0] COS_VAL = cos_entry(PHASE);
        assign cos_rom[k] = COS_VAL;
    end

    // angle + 2*(2*pi) keeps the sum positive without changing it mod 2*pi
    assign prod     = beam_cnt_reg * cfg_angle_step;
    assign acc_init = ACC_W'(prod) + ACC_W'({TWO_PI_UNITS, 1'b0})
                    + {{(ACC_W - ANGLE_W){cfg_start_angle[ANGLE_W-1]}}, cfg_start_angle};
    // reciprocal estimate is at most one below the true quotient
    assign recip_prod = MULT_W'(rem_reg) * MULT_W'(RECIP);
    assign quot_est   = recip_prod[MULT_W-1:WORK_W];
    assign quot_tp    = WORK_W'(quot_reg) * WORK_W'(TWO_PI_UNITS);
    assign ge         = (rem_reg >= WORK_W'(TWO_PI_UNITS));
    assign tidx       = (idx_reg == IDX_W'(COS_TABLE_DEPTH)) ? '0 : idx_reg[TIDX_W-1:0];
    assign is_beam_in = (s_opcode == OP_BEAM);
    assign accept     = s_valid & s_ready;
    assign q_entry    = entry_reg;
    assign q_beam     = beam_idx_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = is_beam_in ? F_REDUCE : F_PUSH;
                end
            end
            F_REDUCE: begin
                if (step_reg == '0) begin
                    state_next = F_SCALE;
                end
            end
            F_SCALE: begin
                state_next = F_INDEX;
            end
            F_INDEX: begin
                if (step_reg == '0) begin
                    state_next = F_LOOKUP;
                end
            end
            F_LOOKUP: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = (state_reg == F_IDLE);
        q_valid = (state_reg == F_PUSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            beam_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (accept && is_beam_in) begin
                if (s_last_beam || beam_cnt_reg == BEAM_W'(MAX_BEAMS - 1)) begin
                    beam_cnt_reg <= '0;
                end else begin
                    beam_cnt_reg <= beam_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    entry_reg.is_beam     <= is_beam_in;
                    entry_reg.value       <= s_speed_mm_s;
                    entry_reg.range_mm    <= s_range_mm;
                    entry_reg.range_valid <= s_range_valid;
                    entry_reg.last_beam   <= s_last_beam;
                    beam_idx_reg          <= beam_cnt_reg;
                    rem_reg               <= WORK_W'(acc_init);
                    step_reg              <= STEP_MUL;
                end
            end
            F_REDUCE: begin
                if (step_reg == STEP_MUL) begin
                    quot_reg <= quot_est;
                end else if (step_reg == STEP_SUB) begin
                    rem_reg <= rem_reg - quot_tp;
                end else if (ge) begin
                    rem_reg <= rem_reg - WORK_W'(TWO_PI_UNITS);
                end
                step_reg <= step_reg - 1'b1;
            end
            F_SCALE: begin
                rem_reg  <= WORK_W'(rem_reg[ANGLE_W-1:0]) * WORK_W'(COS_TABLE_DEPTH)
                          + WORK_W'(HALF_TWO_PI);
                step_reg <= STEP_MUL;
            end
            F_INDEX: begin
                if (step_reg == STEP_MUL) begin
                    quot_reg <= quot_est;
                end else if (step_reg == STEP_SUB) begin
                    rem_reg <= rem_reg - quot_tp;
                end else begin
                    idx_reg <= IDX_W'(quot_reg) + IDX_W'(ge);
                end
                step_reg <= step_reg - 1'b1;
            end
            F_LOOKUP: begin
                entry_reg.value <= cos_rom[tidx];
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/ttceb_back.sv
// ----------------------------------------------------------------------------
// ttceb_back
// Applies speed updates, forms the closing rate, divides range by rate
// bit-serially, tracks the scan minimum and drives the result register.
// ----------------------------------------------------------------------------
module ttceb_back
    import ttceb_pkg::*;
#(
    parameter int MAX_BEAMS = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [TTC_W-1:0]              cfg_brake_thr,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  q_entry_t                      q_entry,
    input  logic [$clog2(MAX_BEAMS)-1:0]  q_beam,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_brake,
    output logic [TTC_W-1:0]              m_min_ttc_ms,
    output logic [MIN_BEAM_W-1:0]         m_min_beam
);

    localparam int BEAM_W = $clog2(MAX_BEAMS);
    localparam int STEP_W = $clog2(TTC_W);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic signed [15:0]   speed_reg;
    q_entry_t             entry_reg;
    logic [BEAM_W-1:0]    beam_reg;
    logic signed [31:0]   rate_reg;
    logic [30:0]          prem_reg;
    logic [15:0]          nlow_reg;
    logic [TTC_W-1:0]     ttc_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [TTC_W-1:0]     min_ttc_reg;
    logic [BEAM_W-1:0]    min_beam_reg;
    logic                 m_valid_reg;
    logic                 brake_reg;
    logic [TTC_W-1:0]     out_ttc_reg;
    logic [MIN_BEAM_W-1:0] out_beam_reg;

    logic                 rate_pos;
    logic [25:0]          prod_ms;
    logic [40:0]          num;
    logic                 saturate;
    logic [31:0]          trial;
    logic                 trial_ge;
    logic                 take;
    logic [TTC_W-1:0]     new_min;
    logic [BEAM_W-1:0]    new_beam;
    logic                 out_free;
    logic                 pop;
    logic                 finish;
    logic                 emit;

    assign rate_pos = !rate_reg[31] && (rate_reg != '0);
    assign prod_ms  = entry_reg.range_mm * MS_PER_S;
    assign num      = {prod_ms, 15'd0};
    assign saturate = !entry_reg.range_valid || !rate_pos
                    || ({6'd0, num} >= {rate_reg[30:0], 16'd0});
    assign trial    = {prem_reg, nlow_reg[15]};
    assign trial_ge = (trial >= {1'b0, rate_reg[30:0]});
    assign take     = (ttc_reg < min_ttc_reg);
    assign new_min  = take ? ttc_reg : min_ttc_reg;
    assign new_beam = take ? beam_reg : min_beam_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_brake      = brake_reg;
    assign m_min_ttc_ms = out_ttc_reg;
    assign m_min_beam   = out_beam_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid && q_entry.is_beam) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_CHECK;
            end
            B_CHECK: begin
                state_next = saturate ? B_UPDATE : B_DIV;
            end
            B_DIV: begin
                if (step_reg == '0) begin
                    state_next = B_UPDATE;
                end
            end
            B_UPDATE: begin
                if (!entry_reg.last_beam || out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        q_ready = (state_reg == B_IDLE);
        pop     = q_valid && (state_reg == B_IDLE);
        finish  = (state_reg == B_UPDATE) && (!entry_reg.last_beam || out_free);
        emit    = finish && entry_reg.last_beam;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            speed_reg    <= '0;
            min_ttc_reg  <= TTC_INF;
            min_beam_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && !q_entry.is_beam) begin
                speed_reg <= q_entry.value;
            end
            if (finish) begin
                if (entry_reg.last_beam) begin
                    min_ttc_reg  <= TTC_INF;
                    min_beam_reg <= '0;
                end else begin
                    min_ttc_reg  <= new_min;
                    min_beam_reg <= new_beam;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            entry_reg <= q_entry;
            beam_reg  <= q_beam;
        end
        case (state_reg)
            B_MUL: begin
                rate_reg <= speed_reg * entry_reg.value;
            end
            B_CHECK: begin
                ttc_reg  <= saturate ? TTC_INF : '0;
                prem_reg <= 31'(num[40:16]);
                nlow_reg <= num[15:0];
                step_reg <= STEP_W'(TTC_W - 1);
            end
            B_DIV: begin
                prem_reg <= trial_ge ? 31'(trial - {1'b0, rate_reg[30:0]}) : trial[30:0];
                nlow_reg <= nlow_reg << 1;
                ttc_reg  <= {ttc_reg[TTC_W-2:0], trial_ge};
                step_reg <= step_reg - 1'b1;
            end
            default: begin
            end
        endcase
        if (emit) begin
            brake_reg    <= (new_min < cfg_brake_thr);
            out_ttc_reg  <= new_min;
            out_beam_reg <= MIN_BEAM_W'(new_beam);
        end
    end

endmodule

// File: design/ttc_emergency_brake.sv
// ----------------------------------------------------------------------------
// ttc_emergency_brake
// Time-to-collision emergency brake over a lidar scan.
// ----------------------------------------------------------------------------
// Input requests (s_*) are either a speed update (opcode 0) or one lidar beam
// (opcode 1). Beams are numbered from zero within a scan; the beam with
// s_last_beam set closes the scan and yields one result on m_*: the brake
// flag, the smallest time to collision in ms (65535 = infinite) and its beam.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// A beam passes the front through two reciprocal divisions by 2*pi, each an
// estimate, a subtraction and a correction, then scale, lookup and push; a
// speed update goes straight to push. The back's 16-step divider sets the beam
// rate and is skipped when the TTC saturates; both sides overlap through a
// two-entry queue.
// A stalled m_ready holds the result; the back waits only when a second
// result is ready, while the front keeps taking requests until the queue fills.
// Reset restores the register defaults, zero speed and an empty scan.
// ----------------------------------------------------------------------------
module ttc_emergency_brake
    import ttceb_pkg::*;
#(
    parameter int MAX_BEAMS       = 2048,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic signed [15:0]      s_speed_mm_s,
    input  logic [15:0]             s_range_mm,
    input  logic                    s_range_valid,
    input  logic                    s_last_beam,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_brake,
    output logic [TTC_W-1:0]        m_min_ttc_ms,
    output logic [MIN_BEAM_W-1:0]   m_min_beam
);

    localparam int BEAM_W = $clog2(MAX_BEAMS);
    localparam int Q_W    = $bits(q_entry_t) + BEAM_W;

    logic signed [ANGLE_W-1:0] start_angle_reg;
    logic [ANGLE_STEP_W-1:0]   angle_step_reg;
    logic [TTC_W-1:0]          brake_thr_reg;

    logic              push_valid;
    logic              push_ready;
    q_entry_t          push_entry;
    logic [BEAM_W-1:0] push_beam;
    logic              pop_valid;
    logic              pop_ready;
    logic [Q_W-1:0]    pop_data;
    q_entry_t          pop_entry;
    logic [BEAM_W-1:0] pop_beam;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= START_ANGLE_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            brake_thr_reg   <= BRAKE_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_ANGLE: start_angle_reg <= cfg_wdata;
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata[ANGLE_STEP_W-1:0];
                REG_BRAKE_THR:   brake_thr_reg   <= cfg_wdata[TTC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ttceb_front #(
        .MAX_BEAMS       (MAX_BEAMS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_start_angle (start_angle_reg),
        .cfg_angle_step  (angle_step_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_speed_mm_s    (s_speed_mm_s),
        .s_range_mm      (s_range_mm),
        .s_range_valid   (s_range_valid),
        .s_last_beam     (s_last_beam),
        .q_valid         (push_valid),
        .q_ready         (push_ready),
        .q_entry         (push_entry),
        .q_beam          (push_beam)
    );

    ttceb_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_entry, push_beam}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    assign pop_entry = pop_data[Q_W-1:BEAM_W];
    assign pop_beam  = pop_data[BEAM_W-1:0];

    ttceb_back #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_brake_thr (brake_thr_reg),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_entry       (pop_entry),
        .q_beam        (pop_beam),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_brake       (m_brake),
        .m_min_ttc_ms  (m_min_ttc_ms),
        .m_min_beam    (m_min_beam)
    );

endmodule
